>>> rtl/seqbit_line_cleared_slot_queue_macros.svh
// assertion macros for the slot queue
`ifndef SEQBIT_LINE_CLEARED_SLOT_QUEUE_MACROS_SVH
`define SEQBIT_LINE_CLEARED_SLOT_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define SBLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SBLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SBLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/sblq_pkg.sv
`default_nettype none

package sblq_pkg;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LINE_SHIFT_W = 3;
  localparam int unsigned COUNT_W      = 9;

  localparam logic [LINE_SHIFT_W-1:0] LINE_SHIFT_RESET = 3'd3;
  localparam logic [LINE_SHIFT_W-1:0] LINE_SHIFT_MAX   = 3'd5;
  localparam logic [COUNT_W-1:0]      COUNT_MAX        = 9'd511;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_e;

endpackage

`default_nettype wire

>>> rtl/sblq_slot_ram.sv
`default_nettype none

module sblq_slot_ram #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned DATA_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/seqbit_line_cleared_slot_queue.sv
// insert/extract: taken in idle, done in execute; input is held off until the result is loaded
// clear of k line heads: the heads are zeroed in turn, then the result is loaded; input held off meanwhile
// the single slot ram port pair is read at accept and written back by an insert in execute
// a result not yet taken holds the next one in execute, adding its wait to that transaction
// reset and every line_shift write start a clearing pass over every slot, input held off
// reset is asynchronous, active low; line_shift returns to 3
`default_nettype none

`include "seqbit_line_cleared_slot_queue_macros.svh"

module seqbit_line_cleared_slot_queue #(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned ITEM_BITS = 31
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [sblq_pkg::LINE_SHIFT_W-1:0]      line_shift_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [sblq_pkg::CMD_W-1:0]             cmd_i,
  input  wire logic [ITEM_BITS-1:0]                   item_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic      [sblq_pkg::STATUS_W-1:0]          status_o,
  output logic      [ITEM_BITS-1:0]                   item_out_o,
  output logic      [sblq_pkg::COUNT_W-1:0]           lines_cleared_o
);

  import sblq_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned DW = ITEM_BITS + 1;
  localparam logic [IW-1:0] RST_LE = IW'(1) << LINE_SHIFT_RESET;

  state_e                  state_q, state_d;
  logic [LINE_SHIFT_W-1:0] ls_q, ls_d, ls_new;
  logic [IW-1:0]           pi_q, pi_d, pc_q, pc_d, ci_q, ci_d, clr_q, clr_d;
  logic [IW-1:0]           le_w, le_new, chk_idx, stop_idx;
  logic [AW-1:0]           sweep_q, sweep_d;
  logic [COUNT_W-1:0]      cnt_q, cnt_d;
  cmd_e                    cmd_q;
  logic [ITEM_BITS-1:0]    item_q;

  logic                    out_valid_q;
  status_e                 status_q, status_d;
  logic [ITEM_BITS-1:0]    item_out_q, item_out_d;
  logic [COUNT_W-1:0]      cleared_q, cleared_d;
  logic                    out_free, load_out, in_ready, accept;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [DW-1:0]           mem_wdata, mem_rdata;
  logic                    chk_needed, is_full, is_empty;

  assign le_w     = IW'(1) << ls_q;
  assign chk_idx  = pc_q + le_w;
  assign stop_idx = ci_q & ~(le_w - IW'(1));
  assign ls_new   = (line_shift_i > LINE_SHIFT_MAX) ? LINE_SHIFT_MAX : line_shift_i;
  assign le_new   = IW'(1) << ls_new;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready;

  // the slot read is issued with the transaction and used in execute; the read data holds until the next read
  assign mem_re    = accept;
  assign mem_raddr = (cmd_e'(cmd_i) == CMD_INSERT) ? chk_idx[AW-1:0] : ci_q[AW-1:0];

  assign chk_needed = (pi_q == pc_q);
  assign is_full    = chk_needed && (mem_rdata != '0);
  assign is_empty   = (mem_rdata == '0) || (mem_rdata[0] != ci_q[AW]);

  always_comb begin
    state_d    = state_q;
    ls_d       = ls_q;
    pi_d       = pi_q;
    pc_d       = pc_q;
    ci_d       = ci_q;
    clr_d      = clr_q;
    sweep_d    = sweep_q;
    cnt_d      = cnt_q;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    status_d   = ST_OK;
    item_out_d = '0;
    cleared_d  = '0;
    mem_we     = 1'b0;
    mem_waddr  = sweep_q;
    mem_wdata  = '0;

    unique case (state_q)
      S_INIT: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cnt_d = '0;
          if (cmd_e'(cmd_i) == CMD_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (item_q == '0) begin
                status_d = ST_ZERO;
              end else if (is_full) begin
                status_d = ST_FULL;
              end else begin
                if (chk_needed) begin
                  pc_d = chk_idx;
                end
                mem_we    = 1'b1;
                mem_waddr = pi_q[AW-1:0];
                mem_wdata = {item_q, pi_q[AW]};
                pi_d      = pi_q + IW'(1);
              end
            end
            CMD_EXTRACT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                ci_d       = ci_q + IW'(1);
                item_out_d = mem_rdata[DW-1:1];
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_q != stop_idx) begin
          // zero one line head a cycle
          mem_we    = 1'b1;
          mem_waddr = clr_q[AW-1:0];
          clr_d     = clr_q + le_w;
          cnt_d     = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
        end else if (out_free) begin
          load_out  = 1'b1;
          cleared_d = cnt_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_valid_i) begin
      ls_d    = ls_new;
      pi_d    = le_new;
      pc_d    = le_new << 1;
      ci_d    = le_new;
      clr_d   = '0;
      sweep_d = '0;
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ls_q    <= LINE_SHIFT_RESET;
      pi_q    <= RST_LE;
      pc_q    <= RST_LE << 1;
      ci_q    <= RST_LE;
      clr_q   <= '0;
      sweep_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ls_q    <= ls_d;
      pi_q    <= pi_d;
      pc_q    <= pc_d;
      ci_q    <= ci_d;
      clr_q   <= clr_d;
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q   <= status_d;
      item_out_q <= item_out_d;
      cleared_q  <= cleared_d;
    end
  end

  sblq_slot_ram #(
    .ADDR_BITS (AW),
    .DATA_BITS (DW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = in_ready;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign item_out_o      = item_out_q;
  assign lines_cleared_o = cleared_q;

  `SBLQ_ASSERT_NEXT(a_extract_to_exec, clk_i, rst_ni,
                    accept && (cmd_e'(cmd_i) == CMD_EXTRACT) && !cfg_valid_i,
                    state_q == S_EXEC, "extract transaction did not reach execute")
  `SBLQ_ASSERT_NEXT(a_extract_step, clk_i, rst_ni,
                    (state_q == S_EXEC) && load_out && (cmd_q == CMD_EXTRACT) &&
                    (status_d == ST_OK) && !cfg_valid_i,
                    ci_q == IW'($past(ci_q) + IW'(1)), "consume index did not step by one")
  `SBLQ_ASSERT_NOW(a_clear_aligned, clk_i, rst_ni, 1'b1,
                   (clr_q & (le_w - IW'(1))) == '0, "clear index off a line boundary")
  `SBLQ_ASSERT_NOW(a_check_window, clk_i, rst_ni, 1'b1,
                   IW'(pc_q - pi_q) <= le_w, "producer check point more than a line ahead")

endmodule

`default_nettype wire
